// ===== rtl/fir_pkg.sv =====
// Shared types and constants for the fixed-point FIR filter.
// Used by the tap cells, the multiply-accumulate unit and the top level.
// Has no dependencies.
package fir_pkg;

	// Filter geometry and field widths.
	localparam int TAPS        = 181;
	localparam int SAMPLE_BITS = 16;
	localparam int DATA_W      = 16;
	localparam int IDX_W       = 8;
	localparam int ACC_W       = 32;
	localparam int SHIFT_W     = 4;
	localparam int CNT_W       = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int SAMPLE_PAD  = DATA_W - SAMPLE_BITS;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(8);

	// Input kinds carried on the slave tuser bit.
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_COEF   = 1'b1;

	// Shift controls broadcast along the tap chain.
	typedef struct packed {
		logic x_shift;
		logic c_shift;
	} cell_ctrl_t;

	// Controls for the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic en;
	} mac_ctrl_t;

	// Takes the low SAMPLE_BITS bits of a value as a signed sample.
	function automatic logic signed [DATA_W-1:0] sext_sample(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] t;
		t = v <<< SAMPLE_PAD;
		return t >>> SAMPLE_PAD;
	endfunction

endpackage

// ===== rtl/fir_filter_fixed_point_top.sv =====
// Top level of the fixed-point FIR filter: tap ring, MAC unit and control.
// Depends on fir_pkg, fir_cell and fir_mac.
//
// Usage:
// The slave stream carries one item per transfer. s_tuser selects its kind:
// 0 filters a sample, 1 writes a coefficient. s_tdata holds tap_index in
// bits 7:0 and the signed value in bits 23:8. A coefficient write produces
// no result; an index of TAPS or more is dropped.
// A sample is shifted into the delay line, and then the ring of tap cells
// rotates once all the way round, past a single multiplier at its head.
// The result leaves on the master stream as a signed 32-bit word.
// A sample keeps the block busy through the rotation, one multiply-accumulate
// per cycle at the ring head, and through the flush and done states; the
// result is posted as the block returns to idle.
// The output register decouples the two sides: a new item is accepted while
// an earlier result waits. If the receiver stalls, a finished result waits
// in the final state until the output register frees up.
// cfg_wr_en writes product_shift (reset value 8) from cfg_wr_data; it must
// only be written while no sample is in flight.
// Reset (arst_n low, asynchronous) clears the delay line, every coefficient,
// the output valid flag and the control state; the output data is not reset.
module fir_filter_fixed_point_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,     // tap_index[7:0], value[23:8]
	input  logic                          s_tuser,     // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,     // filtered_sample[31:0]
	input  logic                          cfg_wr_en,
	input  logic [fir_pkg::SHIFT_W-1:0]   cfg_wr_data
);
	import fir_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [SHIFT_W-1:0]       shift_q;
	logic                     m_tvalid_q;
	logic [ACC_W-1:0]         m_tdata_q;

	logic [IDX_W-1:0]         tap_idx;
	logic signed [DATA_W-1:0] value;
	logic signed [DATA_W-1:0] sample;
	logic                     in_xfer;
	logic                     coef_wr;
	logic                     sample_in;
	logic                     out_load;

	cell_ctrl_t               cell_ctrl;
	mac_ctrl_t                mac_ctrl;
	logic signed [DATA_W-1:0] x_cell [TAPS];
	logic signed [DATA_W-1:0] c_cell [TAPS];
	logic signed [ACC_W-1:0]  acc;

	assign tap_idx   = s_tdata[IDX_W-1:0];
	assign value     = s_tdata[IDX_W +: DATA_W];
	assign sample    = sext_sample(value);

	// Items are only taken between samples; the output register may be full.
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign coef_wr   = in_xfer && (s_tuser == ACT_COEF);
	assign sample_in = in_xfer && (s_tuser == ACT_SAMPLE);
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// A new sample shifts the delay line only; a rotation step moves both
	// samples and coefficients one cell on, so after TAPS steps all is back.
	always_comb begin
		cell_ctrl.x_shift = sample_in || (state_q == ST_RUN);
		cell_ctrl.c_shift = (state_q == ST_RUN);
		mac_ctrl.clear    = sample_in;
		mac_ctrl.en       = (state_q == ST_RUN);
	end

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		logic signed [DATA_W-1:0] x_in;
		logic signed [DATA_W-1:0] c_in;
		logic                     wr_en;

		if (k == 0) begin : g_head
			// The head cell closes the ring, except when a new sample enters.
			assign x_in = (state_q == ST_RUN) ? x_cell[TAPS-1] : sample;
			assign c_in = c_cell[TAPS-1];
		end else begin : g_body
			assign x_in = x_cell[k-1];
			assign c_in = c_cell[k-1];
		end

		assign wr_en = coef_wr && (int'(tap_idx) == k);

		fir_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.x_in   (x_in),
			.c_in   (c_in),
			.wr_en  (wr_en),
			.wr_val (value),
			.x_q    (x_cell[k]),
			.c_q    (c_cell[k])
		);
	end

	// The MAC sees the head cell; over the rotation every tap passes it once.
	fir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.shift  (shift_q),
		.x      (x_cell[0]),
		.c      (c_cell[0]),
		.acc_q  (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RESET;
		end else if (cfg_wr_en) begin
			shift_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sample_in) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (cnt_q == CNT_W'(TAPS - 1)) begin
						state_q <= ST_FLUSH;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_FLUSH: begin
					// The last product is added to the sum in this cycle.
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= acc;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/fir_cell.sv =====
// One tap cell of the FIR ring: holds one delayed sample and one coefficient.
// Depends on fir_pkg.
module fir_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fir_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [fir_pkg::DATA_W-1:0]   x_in,
	input  logic signed [fir_pkg::DATA_W-1:0]   c_in,
	input  logic                                wr_en,
	input  logic signed [fir_pkg::DATA_W-1:0]   wr_val,
	output logic signed [fir_pkg::DATA_W-1:0]   x_q,
	output logic signed [fir_pkg::DATA_W-1:0]   c_q
);
	import fir_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			c_q <= '0;
		end else begin
			if (ctrl.x_shift) begin
				x_q <= x_in;
			end
			if (wr_en) begin
				c_q <= wr_val;
			end else if (ctrl.c_shift) begin
				c_q <= c_in;
			end
		end
	end

endmodule

// ===== rtl/fir_mac.sv =====
// Multiply-accumulate unit at the head of the tap ring.
// Registered product, then arithmetic shift and wrapping 32-bit sum. Depends on fir_pkg.
module fir_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fir_pkg::mac_ctrl_t                  ctrl,
	input  logic [fir_pkg::SHIFT_W-1:0]         shift,
	input  logic signed [fir_pkg::DATA_W-1:0]   x,
	input  logic signed [fir_pkg::DATA_W-1:0]   c,
	output logic signed [fir_pkg::ACC_W-1:0]    acc_q
);
	import fir_pkg::*;

	logic signed [ACC_W-1:0] prod_s1;
	logic                    vld_s1;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_s1 <= ACC_W'(x) * ACC_W'(c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctrl.en && !ctrl.clear;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				// The product fits in 32 bits, so the shift rounds toward minus infinity.
				acc_q <= acc_q + (prod_s1 >>> shift);
			end
		end
	end

endmodule

// ===== rtl/fir_checker.sv =====
// Port-level checks for the FIR filter top level, attached by bind.
// Depends on fir_pkg and fir_filter_fixed_point_top.
module fir_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [31:0]                   m_tdata
);
	import fir_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// A coefficient write never blocks the following item.
	a_coef_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_COEF) |=> s_tready)
		else $error("input stalled after a coefficient write");

	// A sample keeps the block busy while the ring rotates.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_SAMPLE) |=> !s_tready)
		else $error("input taken while a sample is being filtered");

	// A new result is posted only as the block returns to idle.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result posted while the filter is still busy");

endmodule

bind fir_filter_fixed_point_top fir_checker u_fir_checker (.*);
